// File: src/circular_path_moving_average_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circular path moving average unit
// Concurrent checks, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_PATH_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define CIRCULAR_PATH_MOVING_AVERAGE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// prop must hold at every edge out of reset
`define CPMA_ASSERT_ALWAYS(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// cons must hold in the cycle after ante
`define CPMA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`else

`define CPMA_ASSERT_ALWAYS(lbl, ck, rn, prop, msg)
`define CPMA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

// File: src/cpma_pkg.sv
// ----------------------------------------------------------------------------
// cpma_pkg
// Shared constants and types of the circular path moving average unit.
// ----------------------------------------------------------------------------
package cpma_pkg;

	localparam int MAX_POINTS    = 64;
	localparam int WINDOW_RADIUS = 3;
	localparam int COORD_WIDTH   = 16;

	// fixed widths of the channel fields
	localparam int FIELD_W = 16;
	localparam int IDX_W   = 6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REWIND,
		ST_FILL,
		ST_RAW,
		ST_LOAD,
		ST_DIV,
		ST_EMIT,
		ST_SUB,
		ST_ADD
	} cpma_state_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

endpackage

// File: src/cpma_if.sv
// ----------------------------------------------------------------------------
// cpma channel interfaces
// Valid/ready channels for path points in and smoothed results out.
// ----------------------------------------------------------------------------
interface cpma_pt_if;
	logic                                valid;
	logic                                ready;
	logic signed [cpma_pkg::FIELD_W-1:0] x_in;
	logic signed [cpma_pkg::FIELD_W-1:0] y_in;
	logic                                path_done;

	modport source (output valid, output x_in, output y_in, output path_done, input ready);
	modport sink (input valid, input x_in, input y_in, input path_done, output ready);
endinterface

interface cpma_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [cpma_pkg::FIELD_W-1:0] raw_x;
	logic signed [cpma_pkg::FIELD_W-1:0] raw_y;
	logic signed [cpma_pkg::FIELD_W-1:0] smooth_x;
	logic signed [cpma_pkg::FIELD_W-1:0] smooth_y;
	logic        [cpma_pkg::IDX_W-1:0]   point_index;
	logic                                last_point;
	logic                                overflowed;

	modport source (output valid, output raw_x, output raw_y, output smooth_x,
		output smooth_y, output point_index, output last_point, output overflowed,
		input ready);
	modport sink (input valid, input raw_x, input raw_y, input smooth_x,
		input smooth_y, input point_index, input last_point, input overflowed,
		output ready);
endinterface

// File: src/circular_path_moving_average_unit.sv
// ----------------------------------------------------------------------------
// circular_path_moving_average_unit
// Buffers path points and, on path done, emits each point with its centered
// moving average over a circularly wrapped window.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  points    in   x_in, y_in, path_done
//  results   out  raw_x, raw_y, smooth_x, smooth_y, point_index, last_point,
//                 overflowed
//
// A point without path done is accepted while idle. A run over n stored points
// rewinds WINDOW_RADIUS points, fills the window with 2*WINDOW_RADIUS+1 reads,
// then walks RAW, LOAD, DIV and EMIT per result, with SUB and ADD before each
// further one: the single memory read port does three reads per result, and
// the division by the window size is one constant reciprocal multiply.
// points.ready is low for the whole run. A stalled result holds in the output
// register while the next one is computed. arst_n clears control state only;
// the point memory needs no clearing.
// ----------------------------------------------------------------------------
`include "circular_path_moving_average_unit_assert.svh"

module circular_path_moving_average_unit #(
	parameter int MAX_POINTS    = cpma_pkg::MAX_POINTS,
	parameter int WINDOW_RADIUS = cpma_pkg::WINDOW_RADIUS,
	parameter int COORD_WIDTH   = cpma_pkg::COORD_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	cpma_pt_if.sink     points,
	cpma_res_if.source  results
);

	localparam int FIELD_W = cpma_pkg::FIELD_W;
	localparam int IDX_W   = cpma_pkg::IDX_W;
	localparam int WIN     = 2 * WINDOW_RADIUS + 1;
	localparam int ADDR_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int DIV_W   = $clog2(WIN + 1);
	localparam int MAG_W   = COORD_WIDTH - 1 + DIV_W;
	localparam int SUM_W   = MAG_W + 1;
	localparam int RW_W    = (WINDOW_RADIUS > 0) ? $clog2(WINDOW_RADIUS + 1) : 1;
	localparam int FC_W    = $clog2(WIN + 1);
	localparam int MEM_W   = 2 * COORD_WIDTH;
	localparam int SHIFT   = MAG_W + DIV_W;
	localparam int REC_W   = SHIFT + 1;
	localparam int PROD_W  = MAG_W + REC_W;
	// ceil(2^SHIFT / WIN) gives the exact quotient for any magnitude below 2^MAG_W
	localparam logic [REC_W-1:0] RECIP =
		REC_W'(((64'd1 << SHIFT) + 64'(WIN - 1)) / 64'(WIN));

	cpma_pkg::cpma_state_t state_q, state_d;
	cpma_pkg::acc_op_t     op_d, op_s1;

	logic [CNT_W-1:0]  count_q;
	logic              drop_q;
	logic [MEM_W-1:0]  mem [MAX_POINTS];
	logic [MEM_W-1:0]  rd_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] sub_ptr_q, add_ptr_q, idx_q;
	logic [RW_W-1:0]   rw_cnt_q;
	logic [FC_W-1:0]   fill_cnt_q;

	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic [MAG_W-1:0]        dvd_x_q, dvd_y_q;
	logic                    neg_x_q, neg_y_q;
	logic [MEM_W-1:0]        raw_q;

	logic                    out_valid_q;
	logic [FIELD_W-1:0]      out_raw_x_q, out_raw_y_q, out_sm_x_q, out_sm_y_q;
	logic [IDX_W-1:0]        out_idx_q;
	logic                    out_last_q, out_ovf_q;

	logic accept, in_ready, out_free, load_out, is_last, has_room;
	logic [PROD_W-1:0]       prod_x, prod_y;
	logic signed [SUM_W-1:0] quo_x, quo_y;

	function automatic logic [ADDR_W-1:0] inc_wrap(input logic [ADDR_W-1:0] p,
		input logic [CNT_W-1:0] n);
		logic [CNT_W:0] nxt;
		nxt = (CNT_W+1)'(p) + (CNT_W+1)'(1);
		return (nxt == (CNT_W+1)'(n)) ? '0 : ADDR_W'(nxt);
	endfunction

	function automatic logic [ADDR_W-1:0] dec_wrap(input logic [ADDR_W-1:0] p,
		input logic [CNT_W-1:0] n);
		return (p == '0) ? ADDR_W'(n - CNT_W'(1)) : p - ADDR_W'(1);
	endfunction

	assign in_ready = (state_q == cpma_pkg::ST_IDLE);
	assign accept   = points.valid && in_ready;
	assign has_room = (count_q < CNT_W'(MAX_POINTS));
	assign out_free = !out_valid_q || results.ready;
	assign is_last  = ((CNT_W+1)'(idx_q) + (CNT_W+1)'(1)) == (CNT_W+1)'(count_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpma_pkg::ST_IDLE: begin
				if (accept && points.path_done) state_d = cpma_pkg::ST_REWIND;
			end
			cpma_pkg::ST_REWIND: begin
				if (rw_cnt_q == '0) state_d = cpma_pkg::ST_FILL;
			end
			cpma_pkg::ST_FILL: begin
				if (fill_cnt_q == FC_W'(1)) state_d = cpma_pkg::ST_RAW;
			end
			cpma_pkg::ST_RAW:  state_d = cpma_pkg::ST_LOAD;
			cpma_pkg::ST_LOAD: state_d = cpma_pkg::ST_DIV;
			cpma_pkg::ST_DIV:  state_d = cpma_pkg::ST_EMIT;
			cpma_pkg::ST_EMIT: begin
				if (out_free) state_d = is_last ? cpma_pkg::ST_IDLE : cpma_pkg::ST_SUB;
			end
			cpma_pkg::ST_SUB: state_d = cpma_pkg::ST_ADD;
			cpma_pkg::ST_ADD: state_d = cpma_pkg::ST_RAW;
			default:          state_d = cpma_pkg::ST_IDLE;
		endcase
	end

	// read address and what to do with the word when it lands
	always_comb begin
		rd_addr  = idx_q;
		op_d     = cpma_pkg::ACC_NONE;
		load_out = 1'b0;
		unique case (state_q)
			cpma_pkg::ST_FILL: begin
				rd_addr = add_ptr_q;
				op_d    = cpma_pkg::ACC_ADD;
			end
			cpma_pkg::ST_SUB: begin
				rd_addr = sub_ptr_q;
				op_d    = cpma_pkg::ACC_SUB;
			end
			cpma_pkg::ST_ADD: begin
				rd_addr = add_ptr_q;
				op_d    = cpma_pkg::ACC_ADD;
			end
			cpma_pkg::ST_EMIT: load_out = out_free;
			default: ;
		endcase
	end

	// divide magnitudes by the window size, then restore the sign
	always_comb begin
		prod_x = PROD_W'(dvd_x_q) * PROD_W'(RECIP);
		prod_y = PROD_W'(dvd_y_q) * PROD_W'(RECIP);
		quo_x  = neg_x_q ? -$signed({1'b0, dvd_x_q}) : $signed({1'b0, dvd_x_q});
		quo_y  = neg_y_q ? -$signed({1'b0, dvd_y_q}) : $signed({1'b0, dvd_y_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpma_pkg::ST_IDLE;
			op_s1       <= cpma_pkg::ACC_NONE;
			count_q     <= '0;
			drop_q      <= 1'b0;
			sub_ptr_q   <= '0;
			add_ptr_q   <= '0;
			idx_q       <= '0;
			rw_cnt_q    <= '0;
			fill_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_s1   <= op_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				cpma_pkg::ST_IDLE: begin
					if (accept) begin
						if (has_room) count_q <= count_q + CNT_W'(1);
						else drop_q <= 1'b1;
						if (points.path_done) begin
							sub_ptr_q <= '0;
							idx_q     <= '0;
							rw_cnt_q  <= RW_W'(WINDOW_RADIUS);
						end
					end
				end
				cpma_pkg::ST_REWIND: begin
					if (rw_cnt_q != '0) begin
						sub_ptr_q <= dec_wrap(sub_ptr_q, count_q);
						rw_cnt_q  <= rw_cnt_q - RW_W'(1);
					end else begin
						add_ptr_q  <= sub_ptr_q;
						fill_cnt_q <= FC_W'(WIN);
					end
				end
				cpma_pkg::ST_FILL: begin
					add_ptr_q  <= inc_wrap(add_ptr_q, count_q);
					fill_cnt_q <= fill_cnt_q - FC_W'(1);
				end
				cpma_pkg::ST_EMIT: begin
					if (load_out) begin
						if (is_last) begin
							count_q <= '0;
							drop_q  <= 1'b0;
						end else begin
							idx_q <= idx_q + ADDR_W'(1);
						end
					end
				end
				cpma_pkg::ST_SUB: sub_ptr_q <= inc_wrap(sub_ptr_q, count_q);
				cpma_pkg::ST_ADD: add_ptr_q <= inc_wrap(add_ptr_q, count_q);
				default: ;
			endcase
		end
	end

	// point memory: one write port for loading, one registered read port.
	// Loading and the run never overlap, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (accept && has_room) begin
			mem[count_q[ADDR_W-1:0]] <= {COORD_WIDTH'($unsigned(points.x_in)),
				COORD_WIDTH'($unsigned(points.y_in))};
		end
		rd_q <= mem[rd_addr];
	end

	// window sums and divider
	always_ff @(posedge clk) begin
		if (state_q == cpma_pkg::ST_IDLE) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else begin
			unique case (op_s1)
				cpma_pkg::ACC_ADD: begin
					sum_x_q <= sum_x_q + SUM_W'($signed(rd_q[MEM_W-1 -: COORD_WIDTH]));
					sum_y_q <= sum_y_q + SUM_W'($signed(rd_q[COORD_WIDTH-1:0]));
				end
				cpma_pkg::ACC_SUB: begin
					sum_x_q <= sum_x_q - SUM_W'($signed(rd_q[MEM_W-1 -: COORD_WIDTH]));
					sum_y_q <= sum_y_q - SUM_W'($signed(rd_q[COORD_WIDTH-1:0]));
				end
				default: ;
			endcase
		end

		if (state_q == cpma_pkg::ST_LOAD) begin
			raw_q   <= rd_q;
			neg_x_q <= sum_x_q[SUM_W-1];
			neg_y_q <= sum_y_q[SUM_W-1];
			dvd_x_q <= MAG_W'(sum_x_q[SUM_W-1] ? -sum_x_q : sum_x_q);
			dvd_y_q <= MAG_W'(sum_y_q[SUM_W-1] ? -sum_y_q : sum_y_q);
		end else if (state_q == cpma_pkg::ST_DIV) begin
			dvd_x_q <= prod_x[SHIFT +: MAG_W];
			dvd_y_q <= prod_y[SHIFT +: MAG_W];
		end

		if (load_out) begin
			out_raw_x_q <= FIELD_W'(raw_q[MEM_W-1 -: COORD_WIDTH]);
			out_raw_y_q <= FIELD_W'(raw_q[COORD_WIDTH-1:0]);
			out_sm_x_q  <= FIELD_W'(quo_x);
			out_sm_y_q  <= FIELD_W'(quo_y);
			out_idx_q   <= IDX_W'(idx_q);
			out_last_q  <= is_last;
			out_ovf_q   <= drop_q;
		end
	end

	assign points.ready        = in_ready;
	assign results.valid       = out_valid_q;
	assign results.raw_x       = out_raw_x_q;
	assign results.raw_y       = out_raw_y_q;
	assign results.smooth_x    = out_sm_x_q;
	assign results.smooth_y    = out_sm_y_q;
	assign results.point_index = out_idx_q;
	assign results.last_point  = out_last_q;
	assign results.overflowed  = out_ovf_q;

	`CPMA_ASSERT_NEXT(a_run_starts, clk, arst_n, accept && points.path_done, state_q == cpma_pkg::ST_REWIND, "path done beat did not start a run")
	`CPMA_ASSERT_NEXT(a_run_clears, clk, arst_n, load_out && is_last, count_q == '0 && !drop_q, "buffer not emptied after last result")
	`CPMA_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(MAX_POINTS), "point count beyond capacity")

endmodule

// File: tb/sv/tb_circular_path_moving_average_unit.sv
// ----------------------------------------------------------------------------
// tb_circular_path_moving_average_unit
// Sends path points through the valid/ready point channel and checks every
// result beat against a built-in circular window averager: raw point, window
// average truncated toward zero, index, last flag and overflow flag.
// ----------------------------------------------------------------------------
module tb_circular_path_moving_average_unit;

	localparam int MAX_POINTS    = cpma_pkg::MAX_POINTS;
	localparam int WINDOW_RADIUS = cpma_pkg::WINDOW_RADIUS;
	localparam int FIELD_W       = cpma_pkg::FIELD_W;
	localparam int IDX_W         = cpma_pkg::IDX_W;

	localparam int WIN_SIZE    = 2 * WINDOW_RADIUS + 1;
	localparam int N_DIR       = 16;
	localparam int PHASE_ITEMS = 80;
	localparam int N_PHASES    = 4;
	localparam int MAX_PRINTS  = 100;

	typedef struct packed {
		logic signed [FIELD_W-1:0] raw_x;
		logic signed [FIELD_W-1:0] raw_y;
		logic signed [FIELD_W-1:0] smooth_x;
		logic signed [FIELD_W-1:0] smooth_y;
		logic [IDX_W-1:0]          point_index;
		logic                      last_point;
		logic                      overflowed;
	} avg_result_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic                      done;
		logic                      typed;
		avg_result_t               want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	cpma_pt_if  pts();
	cpma_res_if res();

	circular_path_moving_average_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.points (pts),
		.results(res)
	);

	// directed rows; a typed row carries the single result of a one-point path
	dir_row_t dir_rows [N_DIR] = '{
		'{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1,
			'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 6'd0, 1'b1, 1'b0}},
		'{16'sh8000, 16'sh8000, 1'b1, 1'b1,
			'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 6'd0, 1'b1, 1'b0}},
		'{16'shFFFF, 16'sh0001, 1'b1, 1'b1,
			'{16'shFFFF, 16'sh0001, 16'shFFFF, 16'sh0001, 6'd0, 1'b1, 1'b0}},
		// two points: window wraps several times around
		'{16'sh0100, 16'shFF00, 1'b0, 1'b0, '0},
		'{16'shFF00, 16'sh0100, 1'b1, 1'b0, '0},
		// -3/7 must give 0, not -1
		'{16'sh0001, 16'shFFFF, 1'b0, 1'b0, '0},
		'{16'sh0000, 16'sh0000, 1'b0, 1'b0, '0},
		'{16'sh0000, 16'sh0000, 1'b1, 1'b0, '0},
		// longer than the window, every bit toggled
		'{16'sh5555, 16'shAAAA, 1'b0, 1'b0, '0},
		'{16'shAAAA, 16'sh5555, 1'b0, 1'b0, '0},
		'{16'sh7FFF, 16'sh8000, 1'b0, 1'b0, '0},
		'{16'sh8000, 16'sh7FFF, 1'b0, 1'b0, '0},
		'{16'sh00FF, 16'shFF00, 1'b0, 1'b0, '0},
		'{16'shFF00, 16'sh00FF, 1'b0, 1'b0, '0},
		'{16'sh1234, 16'shEDCB, 1'b0, 1'b0, '0},
		'{16'sh0F0F, 16'shF0F0, 1'b1, 1'b0, '0}
	};

	int idle_pct_tab  [N_PHASES] = '{0, 87, 0, 11};
	int stall_pct_tab [N_PHASES] = '{0, 0, 87, 11};

	int send_idle_pct;
	int recv_stall_pct;
	int items_sent;
	int mismatch_count;

	// predictor state
	logic signed [FIELD_W-1:0] path_x [MAX_POINTS];
	logic signed [FIELD_W-1:0] path_y [MAX_POINTS];
	int                        stored_cnt;
	bit                        drop_seen;
	avg_result_t               expected_results [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic void queue_result(input avg_result_t r);
		expected_results = {expected_results, r};
	endfunction

	// Store or drop the point; on path done, average the whole stored path.
	function automatic void absorb_point(input logic signed [FIELD_W-1:0] x,
			input logic signed [FIELD_W-1:0] y, input logic done, input bit keep);
		longint      sum_x;
		longint      sum_y;
		int          n;
		int          k;
		avg_result_t r;
		if (stored_cnt < MAX_POINTS) begin
			path_x[stored_cnt] = x;
			path_y[stored_cnt] = y;
			stored_cnt++;
		end else begin
			drop_seen = 1'b1;
		end
		if (!done)
			return;
		n = stored_cnt;
		for (int i = 0; i < n; i++) begin
			sum_x = 0;
			sum_y = 0;
			for (int j = -WINDOW_RADIUS; j <= WINDOW_RADIUS; j++) begin
				// offset keeps the index positive before the modulo
				k = (i + j + n * (WINDOW_RADIUS + 1)) % n;
				sum_x += path_x[k];
				sum_y += path_y[k];
			end
			r.raw_x       = path_x[i];
			r.raw_y       = path_y[i];
			r.smooth_x    = FIELD_W'(sum_x / WIN_SIZE);
			r.smooth_y    = FIELD_W'(sum_y / WIN_SIZE);
			r.point_index = IDX_W'(i);
			r.last_point  = (i == n - 1);
			r.overflowed  = drop_seen;
			if (keep)
				queue_result(r);
		end
		stored_cnt = 0;
		drop_seen  = 1'b0;
	endfunction

	function automatic logic signed [FIELD_W-1:0] pick_coord();
		logic signed [FIELD_W-1:0] v;
		case ($urandom_range(3))
			0: v = FIELD_W'($urandom);
			1: begin
				case ($urandom_range(3))
					0: v = 16'sh7FFF;
					1: v = 16'sh8000;
					2: v = 16'sh0000;
					default: v = 16'shFFFF;
				endcase
			end
			2: v = FIELD_W'($urandom_range(1023)) - 16'sd512;
			default: v = FIELD_W'($urandom_range(32767)) ^ {FIELD_W{$urandom_range(1) == 1}};
		endcase
		return v;
	endfunction

	function automatic int pick_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(MAX_POINTS - 4, MAX_POINTS + 8);
		return $urandom_range(1, 16);
	endfunction

	task automatic flag_mismatch(input string what, input int at, input longint got,
			input longint want);
		// keep the log short on a badly broken design
		if (mismatch_count < MAX_PRINTS)
			$display("ERROR %s at point %0d: got %0d, expected %0d", what, at, got, want);
		mismatch_count++;
	endtask

	task automatic send_point(input logic signed [FIELD_W-1:0] x,
			input logic signed [FIELD_W-1:0] y, input logic done, input bit typed,
			input avg_result_t want);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			pts.valid <= 1'b0;
			@(posedge clk);
		end
		pts.valid     <= 1'b1;
		pts.x_in      <= x;
		pts.y_in      <= y;
		pts.path_done <= done;
		do @(posedge clk); while (pts.ready !== 1'b1);
		absorb_point(x, y, done, !typed);
		if (typed)
			queue_result(want);
		items_sent++;
	endtask

	task automatic send_path(input int len);
		for (int p = 0; p < len; p++)
			send_point(pick_coord(), pick_coord(), p == len - 1, 1'b0, '0);
	endtask

	always @(posedge clk)
		res.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin : result_check
		avg_result_t want;
		if (arst_n && res.valid === 1'b1 && res.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				flag_mismatch("unexpected result beat", res.point_index, 0, 0);
			end else begin
				want = expected_results.pop_front();
				if (res.raw_x !== want.raw_x)
					flag_mismatch("raw_x", want.point_index, res.raw_x, want.raw_x);
				if (res.raw_y !== want.raw_y)
					flag_mismatch("raw_y", want.point_index, res.raw_y, want.raw_y);
				if (res.smooth_x !== want.smooth_x)
					flag_mismatch("smooth_x", want.point_index, res.smooth_x, want.smooth_x);
				if (res.smooth_y !== want.smooth_y)
					flag_mismatch("smooth_y", want.point_index, res.smooth_y, want.smooth_y);
				if (res.point_index !== want.point_index)
					flag_mismatch("point_index", want.point_index, res.point_index,
						want.point_index);
				if (res.last_point !== want.last_point)
					flag_mismatch("last_point", want.point_index, res.last_point,
						want.last_point);
				if (res.overflowed !== want.overflowed)
					flag_mismatch("overflowed", want.point_index, res.overflowed,
						want.overflowed);
			end
		end
	end

	initial begin
		int target;
		arst_n         = 1'b0;
		pts.valid      = 1'b0;
		pts.x_in       = '0;
		pts.y_in       = '0;
		pts.path_done  = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		items_sent     = 0;
		mismatch_count = 0;
		stored_cnt     = 0;
		drop_seen      = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			send_point(dir_rows[r].x, dir_rows[r].y, dir_rows[r].done, dir_rows[r].typed,
				dir_rows[r].want);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			send_idle_pct  = idle_pct_tab[ph];
			recv_stall_pct = stall_pct_tab[ph];
			target         = items_sent + PHASE_ITEMS;
			// one forced path per phase: full buffer with path done on the dropped
			// point, exactly full, several drops, exactly one window
			case (ph)
				0: send_path(MAX_POINTS + 1);
				1: send_path(MAX_POINTS);
				2: send_path($urandom_range(MAX_POINTS + 2, MAX_POINTS + 8));
				default: send_path(WIN_SIZE);
			endcase
			while (items_sent < target)
				send_path(pick_len());
		end
		pts.valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
